[src/rrvg_pkg.sv]
// Shared types, constants and register codes for the rounded rectangle gradient core.
package rrvg_pkg;

  localparam int MAX_DIM = 4096;

  localparam int COORD_W = 13;
  localparam int ORG_W   = 12;
  localparam int DIM_W   = 13;
  localparam int RAD_W   = 12;
  localparam int COLOR_W = 32;
  localparam int CH_W    = 8;
  localparam int N_CH    = COLOR_W / CH_W;
  localparam int ROW_W   = $clog2(MAX_DIM);
  localparam int SQ_W    = 2 * RAD_W;
  localparam int NUM_W   = CH_W + ROW_W;
  localparam int QUO_W   = CH_W;
  localparam int DIV_STAGES     = 4;
  localparam int BITS_PER_STAGE = QUO_W / DIV_STAGES;

  // Pipeline taps: tap 0 is the geometry register, the last tap feeds the output register.
  localparam int DRAW_TAP = 2;
  localparam int LAST_TAP = DIV_STAGES + 1;
  localparam int PIPE_LAT = LAST_TAP + 2;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X      = 3'd0,
    CFG_ORIGIN_Y      = 3'd1,
    CFG_RECT_WIDTH    = 3'd2,
    CFG_RECT_HEIGHT   = 3'd3,
    CFG_CORNER_RADIUS = 3'd4,
    CFG_START_COLOR   = 3'd5,
    CFG_END_COLOR     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
  } in_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic               draw_enable;
    logic [CH_W-1:0]    red;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    blue;
    logic [CH_W-1:0]    alpha;
  } out_t;

  // Register contents as seen by the datapath; width and height already saturated.
  typedef struct packed {
    logic [ORG_W-1:0]   origin_x;
    logic [ORG_W-1:0]   origin_y;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [RAD_W-1:0]   radius;
    logic [COLOR_W-1:0] start_color;
    logic [COLOR_W-1:0] end_color;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic               row_in;
    logic               in_rect;
    logic [RAD_W-1:0]   dx_mag;
    logic [RAD_W-1:0]   dy_mag;
    logic [ROW_W-1:0]   row;
  } geo_t;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] lim;
    lim = DIM_W'(MAX_DIM);
    return (v > lim) ? lim : v;
  endfunction

endpackage

[src/rounded_rect_vertical_gradient_core.sv]
// Top level of the rounded rectangle vertical gradient core.
// One pixel is taken in every clock cycle; busy never rises. The result of an accepted pixel
// is on out_valid/out_data for exactly one cycle, and results come out in order. A pixel
// passes one geometry stage, one multiply stage, the gradient divider of four stages of two
// quotient bits each, and then the output register. The receiver cannot stall the core, so
// out_data must be taken in the cycle that out_valid is high.
// Register writes take effect at once; write them only while no pixel is in flight.
module rounded_rect_vertical_gradient_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  rrvg_pkg::in_t                     in_data,
  output logic                              out_valid,
  output rrvg_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [rrvg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rrvg_pkg::COLOR_W-1:0]      cfg_wdata
);

  localparam int LT = rrvg_pkg::LAST_TAP;
  localparam int DT = rrvg_pkg::DRAW_TAP;

  rrvg_pkg::cfg_t cfg;
  rrvg_pkg::geo_t geo_a;
  logic           draw_c;
  logic           accept;

  logic                           vld_r    [0:LT];
  logic [rrvg_pkg::COORD_W-1:0]   x_r      [1:LT];
  logic [rrvg_pkg::COORD_W-1:0]   y_r      [1:LT];
  logic                           row_in_r [1:LT];
  logic                           draw_r   [DT+1:LT];
  logic [rrvg_pkg::CH_W-1:0]      ch_val   [0:rrvg_pkg::N_CH-1];

  logic                           out_valid_r;
  rrvg_pkg::out_t                 out_data_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  rrvg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rrvg_geom u_geom (
    .clk     (clk),
    .in_data (in_data),
    .cfg     (cfg),
    .geo_a   (geo_a),
    .draw_c  (draw_c)
  );

  // Channel 0 is red in the top byte of the packed colors.
  for (genvar c = 0; c < rrvg_pkg::N_CH; c++) begin : g_ch
    localparam int SH = (rrvg_pkg::N_CH - 1 - c) * rrvg_pkg::CH_W;
    rrvg_chan u_chan (
      .clk      (clk),
      .start_ch (cfg.start_color[SH +: rrvg_pkg::CH_W]),
      .end_ch   (cfg.end_color[SH +: rrvg_pkg::CH_W]),
      .height   (cfg.height),
      .row      (geo_a.row),
      .value    (ch_val[c])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= LT; i++) begin
        vld_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      vld_r[0] <= accept;
      for (int i = 1; i <= LT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      out_valid_r <= vld_r[LT];
    end
  end

  always_ff @(posedge clk) begin
    x_r[1]      <= geo_a.px;
    y_r[1]      <= geo_a.py;
    row_in_r[1] <= geo_a.row_in;
    for (int i = 2; i <= LT; i++) begin
      x_r[i]      <= x_r[i-1];
      y_r[i]      <= y_r[i-1];
      row_in_r[i] <= row_in_r[i-1];
    end
    draw_r[DT+1] <= draw_c;
    for (int i = DT + 2; i <= LT; i++) begin
      draw_r[i] <= draw_r[i-1];
    end
  end

  // Rows outside the rectangle report a black, transparent color.
  always_ff @(posedge clk) begin
    out_data_r.out_x       <= x_r[LT];
    out_data_r.out_y       <= y_r[LT];
    out_data_r.draw_enable <= draw_r[LT];
    out_data_r.red         <= row_in_r[LT] ? ch_val[0] : '0;
    out_data_r.green       <= row_in_r[LT] ? ch_val[1] : '0;
    out_data_r.blue        <= row_in_r[LT] ? ch_val[2] : '0;
    out_data_r.alpha       <= row_in_r[LT] ? ch_val[3] : '0;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/rrvg_cfg.sv]
// Configuration register file with saturation of the rectangle dimensions.
module rrvg_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rrvg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rrvg_pkg::COLOR_W-1:0]      cfg_wdata,
  output rrvg_pkg::cfg_t                    cfg
);

  logic [rrvg_pkg::ORG_W-1:0]   origin_x_r;
  logic [rrvg_pkg::ORG_W-1:0]   origin_y_r;
  logic [rrvg_pkg::DIM_W-1:0]   width_r;
  logic [rrvg_pkg::DIM_W-1:0]   height_r;
  logic [rrvg_pkg::RAD_W-1:0]   radius_r;
  logic [rrvg_pkg::COLOR_W-1:0] start_color_r;
  logic [rrvg_pkg::COLOR_W-1:0] end_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r    <= '0;
      origin_y_r    <= '0;
      width_r       <= rrvg_pkg::DIM_W'(1);
      height_r      <= rrvg_pkg::DIM_W'(1);
      radius_r      <= '0;
      start_color_r <= '0;
      end_color_r   <= '0;
    end else if (cfg_we) begin
      unique case (rrvg_pkg::cfg_reg_t'(cfg_index))
        rrvg_pkg::CFG_ORIGIN_X:      origin_x_r    <= cfg_wdata[rrvg_pkg::ORG_W-1:0];
        rrvg_pkg::CFG_ORIGIN_Y:      origin_y_r    <= cfg_wdata[rrvg_pkg::ORG_W-1:0];
        rrvg_pkg::CFG_RECT_WIDTH:    width_r       <= cfg_wdata[rrvg_pkg::DIM_W-1:0];
        rrvg_pkg::CFG_RECT_HEIGHT:   height_r      <= cfg_wdata[rrvg_pkg::DIM_W-1:0];
        rrvg_pkg::CFG_CORNER_RADIUS: radius_r      <= cfg_wdata[rrvg_pkg::RAD_W-1:0];
        rrvg_pkg::CFG_START_COLOR:   start_color_r <= cfg_wdata;
        rrvg_pkg::CFG_END_COLOR:     end_color_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.origin_x    = origin_x_r;
    cfg.origin_y    = origin_y_r;
    cfg.width       = rrvg_pkg::sat_dim(width_r);
    cfg.height      = rrvg_pkg::sat_dim(height_r);
    cfg.radius      = radius_r;
    cfg.start_color = start_color_r;
    cfg.end_color   = end_color_r;
  end

endmodule

[src/rrvg_geom.sv]
// Rectangle membership and rounded corner test, three register stages.
module rrvg_geom (
  input  logic            clk,
  input  rrvg_pkg::in_t   in_data,
  input  rrvg_pkg::cfg_t  cfg,
  output rrvg_pkg::geo_t  geo_a,
  output logic            draw_c
);

  logic signed [15:0] px_s, py_s, x0_s, y0_s, x1_s, y1_s, r_s;
  logic signed [15:0] xl_s, xh_s, yl_s, yh_s, dx_s, dy_s, dx_abs, dy_abs;
  logic               row_in, in_rect, on_corner;

  rrvg_pkg::geo_t             geo_r;
  logic [rrvg_pkg::SQ_W-1:0]  dx2_r, dy2_r, rr_r;
  logic                       in_rect_b_r;
  logic                       draw_r;

  always_comb begin
    px_s = signed'({3'b0, in_data.pixel_x});
    py_s = signed'({3'b0, in_data.pixel_y});
    x0_s = signed'({4'b0, cfg.origin_x});
    y0_s = signed'({4'b0, cfg.origin_y});
    x1_s = x0_s + signed'({3'b0, cfg.width}) - 16'sd1;
    y1_s = y0_s + signed'({3'b0, cfg.height}) - 16'sd1;
    r_s  = signed'({4'b0, cfg.radius});
    xl_s = x0_s + r_s;
    xh_s = x1_s - r_s;
    yl_s = y0_s + r_s;
    yh_s = y1_s - r_s;

    row_in  = (cfg.width != '0) && (cfg.height != '0) && (py_s >= y0_s) && (py_s <= y1_s);
    in_rect = row_in && (px_s >= x0_s) && (px_s <= x1_s);

    // The row offset only counts when the column lies in a corner band.
    on_corner = 1'b1;
    dx_s      = 16'sd0;
    dy_s      = 16'sd0;
    if (px_s < xl_s) begin
      dx_s = px_s - xl_s;
    end else if (px_s >= xh_s) begin
      dx_s = px_s - xh_s;
    end else begin
      on_corner = 1'b0;
    end
    if (on_corner) begin
      if (py_s < yl_s) begin
        dy_s = py_s - yl_s;
      end else if (py_s >= yh_s) begin
        dy_s = py_s - yh_s;
      end
    end
    dx_abs = (dx_s < 16'sd0) ? -dx_s : dx_s;
    dy_abs = (dy_s < 16'sd0) ? -dy_s : dy_s;
  end

  always_ff @(posedge clk) begin
    geo_r.px      <= in_data.pixel_x;
    geo_r.py      <= in_data.pixel_y;
    geo_r.row_in  <= row_in;
    geo_r.in_rect <= in_rect;
    geo_r.dx_mag  <= dx_abs[rrvg_pkg::RAD_W-1:0];
    geo_r.dy_mag  <= dy_abs[rrvg_pkg::RAD_W-1:0];
    geo_r.row     <= rrvg_pkg::ROW_W'(py_s - y0_s);
  end

  always_ff @(posedge clk) begin
    dx2_r       <= geo_r.dx_mag * geo_r.dx_mag;
    dy2_r       <= geo_r.dy_mag * geo_r.dy_mag;
    rr_r        <= cfg.radius * cfg.radius;
    in_rect_b_r <= geo_r.in_rect;
  end

  always_ff @(posedge clk) begin
    draw_r <= in_rect_b_r &&
              (({1'b0, dx2_r} + {1'b0, dy2_r}) <= {1'b0, rr_r});
  end

  assign geo_a  = geo_r;
  assign draw_c = draw_r;

endmodule

[src/rrvg_chan.sv]
// One color channel: scaled difference, pipelined restoring divide and floor correction.
module rrvg_chan (
  input  logic                          clk,
  input  logic [rrvg_pkg::CH_W-1:0]     start_ch,
  input  logic [rrvg_pkg::CH_W-1:0]     end_ch,
  input  logic [rrvg_pkg::DIM_W-1:0]    height,
  input  logic [rrvg_pkg::ROW_W-1:0]    row,
  output logic [rrvg_pkg::CH_W-1:0]     value
);

  localparam int NS = rrvg_pkg::DIV_STAGES;

  logic [rrvg_pkg::NUM_W-1:0] rem_r [0:NS];
  logic [rrvg_pkg::QUO_W-1:0] quo_r [0:NS];
  logic [rrvg_pkg::CH_W-1:0]  s_r   [0:NS];
  logic                       neg_r [0:NS];

  logic                       neg_nxt;
  logic [rrvg_pkg::CH_W-1:0]  mag_nxt;

  always_comb begin
    neg_nxt = end_ch < start_ch;
    mag_nxt = neg_nxt ? (start_ch - end_ch) : (end_ch - start_ch);
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= mag_nxt * row;
    quo_r[0] <= '0;
    s_r[0]   <= start_ch;
    neg_r[0] <= neg_nxt;
  end

  // Inside the rectangle the row is below the height, so the quotient fits in one channel width.
  for (genvar k = 0; k < NS; k++) begin : g_div
    logic [rrvg_pkg::NUM_W-1:0] rem_nxt;
    logic [rrvg_pkg::QUO_W-1:0] quo_nxt;

    always_comb begin
      logic [rrvg_pkg::NUM_W:0] trial;
      rem_nxt = rem_r[k];
      quo_nxt = quo_r[k];
      for (int j = 0; j < rrvg_pkg::BITS_PER_STAGE; j++) begin
        trial = {1'b0, rem_nxt} -
                (((rrvg_pkg::NUM_W + 1)'(height)) <<
                 (rrvg_pkg::QUO_W - 1 - k * rrvg_pkg::BITS_PER_STAGE - j));
        if (!trial[rrvg_pkg::NUM_W]) begin
          rem_nxt = trial[rrvg_pkg::NUM_W-1:0];
          quo_nxt[rrvg_pkg::QUO_W - 1 - k * rrvg_pkg::BITS_PER_STAGE - j] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k+1] <= rem_nxt;
      quo_r[k+1] <= quo_nxt;
      s_r[k+1]   <= s_r[k];
      neg_r[k+1] <= neg_r[k];
    end
  end

  // A falling ramp rounds toward minus infinity, so a nonzero remainder adds one step.
  logic [rrvg_pkg::CH_W:0]   quo_up;
  logic signed [rrvg_pkg::CH_W+1:0] sum;

  always_comb begin
    quo_up = {1'b0, quo_r[NS]} + (rrvg_pkg::CH_W + 1)'(rem_r[NS] != '0);
    if (neg_r[NS]) begin
      sum = signed'({2'b0, s_r[NS]}) - signed'({1'b0, quo_up});
    end else begin
      sum = signed'({2'b0, s_r[NS]}) + signed'({2'b0, quo_r[NS]});
    end
    if (sum[rrvg_pkg::CH_W+1]) begin
      value = '0;
    end else if (sum[rrvg_pkg::CH_W]) begin
      value = '1;
    end else begin
      value = sum[rrvg_pkg::CH_W-1:0];
    end
  end

endmodule

[src/rrvg_chk.sv]
// Port-level checker for the gradient core and its bind to the top level.
module rrvg_chk (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  rrvg_pkg::in_t                     in_data,
  input  logic                              out_valid,
  input  rrvg_pkg::out_t                    out_data
);

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(rrvg_pkg::PIPE_LAT) out_valid)
    else $error("accepted pixel produced no result at the expected cycle");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, rrvg_pkg::PIPE_LAT))
    else $error("result strobe without a matching transfer in");

  a_x_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.out_x == $past(in_data.pixel_x, rrvg_pkg::PIPE_LAT)))
    else $error("column of result does not match its pixel");

  a_y_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.out_y == $past(in_data.pixel_y, rrvg_pkg::PIPE_LAT)))
    else $error("row of result does not match its pixel");

endmodule

bind rounded_rect_vertical_gradient_core rrvg_chk u_rrvg_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

[tb/tb_rounded_rect_vertical_gradient_core.sv]
// Self-checking testbench for the rounded rectangle vertical gradient core.
module tb_rounded_rect_vertical_gradient_core;
  import rrvg_pkg::*;

  // Unused register index; writes to it must leave every register alone.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
  localparam int COORD_MAX = (1 << COORD_W) - 1;

  class pixel_shade_board;
    logic [ORG_W-1:0]   org_x, org_y;
    logic [DIM_W-1:0]   dim_w, dim_h;
    logic [RAD_W-1:0]   radius;
    logic [COLOR_W-1:0] top_color, bottom_color;
    out_t               expected_shades[$];
    int                 failures;

    function new();
      org_x = '0;
      org_y = '0;
      dim_w = DIM_W'(1);
      dim_h = DIM_W'(1);
      radius = '0;
      top_color = '0;
      bottom_color = '0;
      failures = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] data);
      case (idx)
        CFG_ORIGIN_X:      org_x = data[ORG_W-1:0];
        CFG_ORIGIN_Y:      org_y = data[ORG_W-1:0];
        CFG_RECT_WIDTH:    dim_w = data[DIM_W-1:0];
        CFG_RECT_HEIGHT:   dim_h = data[DIM_W-1:0];
        CFG_CORNER_RADIUS: radius = data[RAD_W-1:0];
        CFG_START_COLOR:   top_color = data;
        CFG_END_COLOR:     bottom_color = data;
        default: ;
      endcase
    endfunction

    // start + floor((end - start) * row / h), clamped to a byte.
    function logic [CH_W-1:0] blend(logic [CH_W-1:0] s8, logic [CH_W-1:0] e8,
                                    longint row, longint h);
      longint s, e, num, q, v;
      s = s8;
      e = e8;
      num = (e - s) * row;
      if (num >= 0) q = num / h;
      else q = -((-num + h - 1) / h);
      v = s + q;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return CH_W'(v);
    endfunction

    function void note_pixel(in_t p);
      longint px, py, w, h, x0, y0, x1, y1, r, dx, dy, row;
      bit row_in, in_rect, on_corner;
      out_t o;
      px = p.pixel_x;
      py = p.pixel_y;
      w = dim_w;
      h = dim_h;
      if (w > MAX_DIM) w = MAX_DIM;
      if (h > MAX_DIM) h = MAX_DIM;
      x0 = org_x;
      y0 = org_y;
      x1 = x0 + w - 1;
      y1 = y0 + h - 1;
      r = radius;
      row_in = (w > 0) && (h > 0) && (py >= y0) && (py <= y1);
      in_rect = row_in && (px >= x0) && (px <= x1);
      o = '0;
      o.out_x = p.pixel_x;
      o.out_y = p.pixel_y;
      if (row_in) begin
        row = py - y0;
        o.red   = blend(top_color[31:24], bottom_color[31:24], row, h);
        o.green = blend(top_color[23:16], bottom_color[23:16], row, h);
        o.blue  = blend(top_color[15:8],  bottom_color[15:8],  row, h);
        o.alpha = blend(top_color[7:0],   bottom_color[7:0],   row, h);
      end
      if (in_rect) begin
        dx = 0;
        dy = 0;
        on_corner = 1'b1;
        if (px < x0 + r) dx = px - (x0 + r);
        else if (px >= x1 - r) dx = px - (x1 - r);
        else on_corner = 1'b0;
        // The row offset only counts in the corner columns.
        if (on_corner) begin
          if (py < y0 + r) dy = py - (y0 + r);
          else if (py >= y1 - r) dy = py - (y1 - r);
        end
        o.draw_enable = (dx * dx + dy * dy) <= r * r;
      end
      expected_shades = {expected_shades, o};
    endfunction

    function void compare_field(string name, longint exp_v, longint got_v);
      if (exp_v != got_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
        failures++;
      end
    endfunction

    function void check_shade(out_t got);
      out_t exp_o;
      if (expected_shades.size() == 0) begin
        $error("result transfer with no pixel outstanding: x %0d y %0d",
               got.out_x, got.out_y);
        failures++;
        return;
      end
      exp_o = expected_shades.pop_front();
      compare_field("out_x", exp_o.out_x, got.out_x);
      compare_field("out_y", exp_o.out_y, got.out_y);
      compare_field("draw_enable", exp_o.draw_enable, got.draw_enable);
      compare_field("red", exp_o.red, got.red);
      compare_field("green", exp_o.green, got.green);
      compare_field("blue", exp_o.blue, got.blue);
      compare_field("alpha", exp_o.alpha, got.alpha);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_t                  in_data;
  logic                 out_valid;
  out_t                 out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COLOR_W-1:0]   cfg_wdata;

  pixel_shade_board board;

  rounded_rect_vertical_gradient_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("rounded_rect_vertical_gradient_core verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) board.note_pixel(in_data);
      if (out_valid) board.check_shade(out_data);
    end
  end

  function automatic in_t pix(input int x, input int y);
    in_t p;
    if (x < 0) x = 0;
    if (x > COORD_MAX) x = COORD_MAX;
    if (y < 0) y = 0;
    if (y > COORD_MAX) y = COORD_MAX;
    p.pixel_x = COORD_W'(x);
    p.pixel_y = COORD_W'(y);
    return p;
  endfunction

  // Pixels mostly land on or around the rectangle and its corner arcs.
  function automatic in_t aim_pixel();
    int x0, y0, w, h, span, mode, cx, cy;
    x0 = board.org_x;
    y0 = board.org_y;
    w = (board.dim_w > MAX_DIM) ? MAX_DIM : board.dim_w;
    h = (board.dim_h > MAX_DIM) ? MAX_DIM : board.dim_h;
    span = int'(board.radius) + 3;
    mode = $urandom_range(99);
    if (mode < 20) return pix($urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
    if (mode < 50) begin
      cx = $urandom_range(1) ? x0 : x0 + w - 1;
      cy = $urandom_range(1) ? y0 : y0 + h - 1;
      return pix(cx - span + int'($urandom_range(2 * span)),
                 cy - span + int'($urandom_range(2 * span)));
    end
    return pix(x0 - 4 + int'($urandom_range(w + 8)), y0 - 4 + int'($urandom_range(h + 8)));
  endfunction

  task automatic send_pixel(input in_t p, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= p;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // Holds the sender off until every outstanding pixel has come back.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (board.expected_shades.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    board.write_reg(idx, data);
  endtask

  // Optionally sets the bits above a register's width, which must be dropped.
  function automatic logic [COLOR_W-1:0] pad_word(input int value, input int bits,
                                                  input bit noisy);
    logic [COLOR_W-1:0] word;
    word = COLOR_W'(value) & COLOR_W'((64'd1 << bits) - 1);
    if (noisy && bits < COLOR_W && $urandom_range(1)) word = word | ($urandom() << bits);
    return word;
  endfunction

  task automatic load_config(input int ox, input int oy, input int w, input int h,
                             input int r, input logic [COLOR_W-1:0] c0,
                             input logic [COLOR_W-1:0] c1, input bit noisy);
    write_reg(CFG_ORIGIN_X, pad_word(ox, ORG_W, noisy));
    write_reg(CFG_ORIGIN_Y, pad_word(oy, ORG_W, noisy));
    write_reg(CFG_RECT_WIDTH, pad_word(w, DIM_W, noisy));
    write_reg(CFG_RECT_HEIGHT, pad_word(h, DIM_W, noisy));
    write_reg(CFG_CORNER_RADIUS, pad_word(r, RAD_W, noisy));
    write_reg(CFG_START_COLOR, c0);
    write_reg(CFG_END_COLOR, c1);
    if (noisy && $urandom_range(1)) write_reg(CFG_SPARE_IDX, $urandom());
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_dim();
    case ($urandom_range(11))
      0: return 0;
      1: return 1;
      2: return MAX_DIM;
      3: return $urandom_range(MAX_DIM + 1, (1 << DIM_W) - 1);
      4: return $urandom_range(2, MAX_DIM);
      default: return $urandom_range(2, 80);
    endcase
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_config();
    int ox, oy, w, h, r, lim;
    ox = ($urandom_range(7) == 0) ? ORG_W'('1) : $urandom_range((1 << ORG_W) - 1);
    oy = ($urandom_range(7) == 0) ? 0 : $urandom_range((1 << ORG_W) - 1);
    w = pick_dim();
    h = pick_dim();
    lim = ((w < h) ? w : h);
    if (lim > 200) lim = 200;
    case ($urandom_range(9))
      0: r = 0;
      1: r = (1 << RAD_W) - 1;
      2: r = $urandom_range((1 << RAD_W) - 1);
      default: r = $urandom_range(lim / 2 + 2);
    endcase
    load_config(ox, oy, w, h, r, pick_color(), pick_color(), 1'b1);
  endtask

  initial begin
    int idle_pcts[4];
    int guard;
    idle_pcts = '{0, 78, 11, 0};
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    board = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers at their reset values: a single pixel rectangle at the origin.
    send_pixel(pix(0, 0), 0);
    send_pixel(pix(1, 0), 0);
    send_pixel(pix(0, 1), 0);
    send_pixel(pix(COORD_MAX, COORD_MAX), 0);
    wait_idle();

    // A small rectangle with rising, falling and flat channels, probing arcs, edges and outside pixels.
    load_config(100, 200, 64, 32, 8, 32'h10FF2080, 32'hF0004080, 1'b0);
    send_pixel(pix(100, 200), 0);
    send_pixel(pix(108, 200), 0);
    send_pixel(pix(163, 231), 0);
    send_pixel(pix(155, 223), 0);
    send_pixel(pix(131, 215), 0);
    send_pixel(pix(102, 202), 0);
    send_pixel(pix(103, 203), 0);
    send_pixel(pix(99, 210), 0);
    send_pixel(pix(164, 210), 0);
    send_pixel(pix(120, 199), 0);
    send_pixel(pix(120, 232), 0);
    wait_idle();

    // Far corner, oversized width that saturates, and a radius larger than half the rectangle.
    load_config(4095, 4095, 8191, 4096, 4095, 32'hFFFFFFFF, 32'h00000000, 1'b0);
    send_pixel(pix(4095, 4095), 0);
    send_pixel(pix(8190, 8190), 0);
    send_pixel(pix(COORD_MAX, COORD_MAX), 0);
    send_pixel(pix(6000, 6000), 0);
    wait_idle();

    // Zero width, then zero height: nothing is inside.
    load_config(0, 0, 0, 4096, 2048, 32'h01020304, 32'hFFFFFFFF, 1'b0);
    send_pixel(pix(0, 3), 0);
    send_pixel(pix(0, 0), 0);
    wait_idle();
    load_config(0, 0, 4096, 0, 0, 32'h01020304, 32'hFFFFFFFF, 1'b0);
    send_pixel(pix(5, 0), 0);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      random_config();
      for (int i = 0; i < 212; i++) begin
        if (ph == 2 && i == 106) wait_idle();
        send_pixel(aim_pixel(), idle_pcts[ph % 4]);
      end
      wait_idle();
    end

    start <= 1'b0;
    guard = 0;
    while (board.expected_shades.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (PIPE_LAT + 4) @(posedge clk);
    if (board.expected_shades.size() != 0) begin
      $error("%0d pixels never produced a result", board.expected_shades.size());
      board.failures++;
    end
    if (board.failures == 0) begin
      $display("rounded_rect_vertical_gradient_core verification clean");
    end else begin
      $display("rounded_rect_vertical_gradient_core verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/rrvg_pkg.sv
src/rrvg_cfg.sv
src/rrvg_geom.sv
src/rrvg_chan.sv
src/rounded_rect_vertical_gradient_core.sv
src/rrvg_chk.sv
tb/tb_rounded_rect_vertical_gradient_core.sv
